>>> hw/rtl/gnnm_pkg.sv
// Package for the gallery nearest-neighbor match block.
// Holds command, pose and status codes and the front-to-back request type.
package gnnm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NO_ENTRY = 2'd2,
    ST_BAD_POSE = 2'd3
  } status_t;

  localparam logic [1:0] POSE_BAD = 2'd3;
  localparam int POSES = 3;

  localparam logic [0:0] CFG_DIST = 1'b0;
  localparam logic [0:0] CFG_PCT  = 1'b1;

  localparam int DIST_W = 40;
  localparam int THR_W  = 20;
  localparam int PCT_W  = 14;

  // search request from front to back
  typedef struct packed {
    logic [1:0] pose;
  } search_req_t;

endpackage

>>> hw/rtl/gnnm_if.sv
// Valid/ready channel interfaces for the match block.
// Payloads are plain logic vectors; gnnm_pkg is not used here.
interface gnnm_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [5:0]                    entry;
  logic [1:0]                    pose;
  logic [6:0]                    element_index;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, command, entry, pose, element_index, sample, last,
                  input ready);
  modport sink (input valid, command, entry, pose, element_index, sample, last,
                output ready);
endinterface

interface gnnm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  match_entry;
  logic [39:0] best_distance_sq;
  modport source (output valid, status, match_entry, best_distance_sq, input ready);
  modport sink (input valid, status, match_entry, best_distance_sq, output ready);
endinterface

>>> hw/rtl/gnnm_front.sv
// Front end: takes requests, writes gallery/query memories and valid bits,
// and queues search requests. Depends on gnnm_pkg.
module gnnm_front #(
  parameter int ENTRIES     = 64,
  parameter int VECTOR_LEN  = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int EW = 6,
  parameter int VW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [5:0]                    in_entry,
  input  logic [1:0]                    in_pose,
  input  logic [6:0]                    in_element_index,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          in_last,
  // memory write ports
  output logic                          g_we,
  output logic [EW-1:0]                 g_entry,
  output logic [1:0]                    g_pose,
  output logic [VW-1:0]                 g_idx,
  output logic                          q_we,
  output logic [VW-1:0]                 q_idx,
  output logic [SAMPLE_BITS-1:0]        wr_sample,
  output logic [ENTRIES-1:0]            valid_bits,
  // queue to back end
  output logic                          req_valid,
  output gnnm_pkg::search_req_t         req,
  input  logic                          req_take,
  input  logic                          back_busy
);
  import gnnm_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               qv_r;
  search_req_t        q_r;
  logic               acc, ent_ok, idx_ok;

  // memory contents change only while the back end is not searching
  assign in_ready  = !qv_r && !back_busy;
  assign acc       = in_valid && in_ready;
  assign ent_ok    = 32'(in_entry) < ENTRIES;
  assign idx_ok    = 32'(in_element_index) < VECTOR_LEN;
  assign g_we      = acc && (cmd_t'(in_command) == CMD_WRITE) && ent_ok && idx_ok &&
                     (in_pose != POSE_BAD);
  assign q_we      = acc && (cmd_t'(in_command) == CMD_QUERY) && idx_ok;
  assign g_entry   = in_entry[EW-1:0];
  assign g_pose    = in_pose;
  assign g_idx     = in_element_index[VW-1:0];
  assign q_idx     = in_element_index[VW-1:0];
  assign wr_sample = in_sample;
  assign valid_bits = valid_r;
  assign req_valid = qv_r;
  assign req       = q_r;

  always_comb begin
    valid_nxt = valid_r;
    if (acc && ent_ok) begin
      if (cmd_t'(in_command) == CMD_COMMIT) valid_nxt[in_entry[EW-1:0]] = 1'b1;
      if (cmd_t'(in_command) == CMD_DELETE) valid_nxt[in_entry[EW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (acc && (cmd_t'(in_command) == CMD_QUERY) && in_last) begin
        qv_r <= 1'b1;
      end else if (req_take) begin
        qv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_r.pose <= in_pose;
  end
endmodule

>>> hw/rtl/gnnm_back.sv
// Back end: holds gallery and query memories, walks valid entries with one
// multiply-accumulate per cycle, decides acceptance. Depends on gnnm_pkg.
module gnnm_back #(
  parameter int ENTRIES     = 64,
  parameter int VECTOR_LEN  = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int EW = 6,
  parameter int VW = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   g_we,
  input  logic [EW-1:0]          g_entry,
  input  logic [1:0]             g_pose,
  input  logic [VW-1:0]          g_idx,
  input  logic                   q_we,
  input  logic [VW-1:0]          q_idx,
  input  logic [SAMPLE_BITS-1:0] wr_sample,
  input  logic [ENTRIES-1:0]     valid_bits,
  input  logic                   req_valid,
  input  gnnm_pkg::search_req_t  req,
  output logic                   req_take,
  output logic                   busy,
  input  logic [19:0]            thr,
  input  logic [13:0]            pct,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [5:0]             out_match_entry,
  output logic [39:0]            out_best_distance_sq
);
  import gnnm_pkg::*;

  localparam int DEPTH = ENTRIES * POSES * VECTOR_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = SAMPLE_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DRN  = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_ACC1 = 7'b0010000,
    S_ACC2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  logic [SAMPLE_BITS-1:0] gmem [DEPTH];
  logic [SAMPLE_BITS-1:0] qmem [VECTOR_LEN];
  logic [SAMPLE_BITS-1:0] gdat_r, qdat_r;

  state_t          st_r;
  logic [1:0]      pose_r;
  logic [EW-1:0]   e_r;
  logic [VW-1:0]   i_r;
  logic            rd_v_r, rd_last_r, mul_v_r, mul_last_r;
  logic [EW-1:0]   rd_e_r, mul_e_r;
  logic [2*DW-1:0] sq_r;
  logic [DIST_W-1:0] acc_r, best_r;
  logic [EW-1:0]   best_e_r;
  logic            found_r;
  logic [27:0]     pp_r;
  logic [53:0]     rhs_r;
  logic [47:0]     lhs_lo_r, lhs_hi_r;
  logic [1:0]      stat_r;
  logic            any_v;
  logic [AW-1:0]   waddr, raddr;
  logic signed [DW-1:0] diff;
  logic [DIST_W-1:0] dsum;

  assign any_v = |valid_bits;
  assign waddr = AW'((32'(g_entry) * POSES + 32'(g_pose)) * VECTOR_LEN + 32'(g_idx));
  assign raddr = AW'((32'(e_r) * POSES + 32'(pose_r)) * VECTOR_LEN + 32'(i_r));

  always_ff @(posedge clk) begin
    if (g_we) gmem[waddr] <= wr_sample;
    if (q_we) qmem[q_idx] <= wr_sample;
    gdat_r <= gmem[raddr];
    qdat_r <= qmem[i_r];
  end

  assign diff = DW'($signed(gdat_r)) - DW'($signed(qdat_r));
  assign dsum = acc_r + DIST_W'(sq_r);
  assign busy = (st_r != S_IDLE);
  assign req_take = (st_r == S_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v_r    <= (st_r == S_SCAN) && valid_bits[e_r];
      rd_last_r <= 32'(i_r) == VECTOR_LEN - 1;
      rd_e_r    <= e_r;
      mul_v_r   <= rd_v_r;
      mul_last_r <= rd_last_r;
      mul_e_r   <= rd_e_r;
      sq_r      <= (2*DW)'(diff * diff);
      if (mul_v_r) begin
        if (mul_last_r) begin
          acc_r <= '0;
          if (!found_r || dsum < best_r) begin
            best_r <= dsum; best_e_r <= mul_e_r;
          end
          found_r <= 1'b1;
        end else begin
          acc_r <= dsum;
        end
      end
      if (out_valid && out_ready && st_r != S_OUT) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (req_valid) begin
          pose_r <= req.pose; e_r <= '0; i_r <= '0; acc_r <= '0;
          found_r <= 1'b0; best_r <= '0; best_e_r <= '0;
          if (!any_v) begin
            stat_r <= ST_NO_ENTRY; st_r <= S_OUT;
          end else if (req.pose == POSE_BAD) begin
            stat_r <= ST_BAD_POSE; st_r <= S_OUT;
          end else st_r <= S_SCAN;
        end
        S_SCAN: begin
          // invalid entries are skipped without a multiply-accumulate
          if (!valid_bits[e_r] || 32'(i_r) == VECTOR_LEN - 1) begin
            i_r <= '0;
            if (32'(e_r) == ENTRIES - 1) st_r <= S_DRN;
            else e_r <= e_r + 1'b1;
          end else i_r <= i_r + 1'b1;
        end
        S_DRN: if (!rd_v_r && !mul_v_r) st_r <= S_CMP;
        S_CMP: begin
          pp_r  <= 28'(pct) * 28'(pct);
          rhs_r <= 54'(thr) * 54'(thr);
          st_r  <= S_ACC1;
        end
        S_ACC1: begin
          // pct^2 * best split in two halves of the distance
          lhs_lo_r <= 48'(pp_r) * 48'(best_r[19:0]);
          lhs_hi_r <= 48'(pp_r) * 48'(best_r[39:20]);
          rhs_r    <= rhs_r * 54'd10000;
          st_r     <= S_ACC2;
        end
        S_ACC2: begin
          stat_r <= (best_r == '0 ||
                     (68'(lhs_lo_r) + (68'(lhs_hi_r) << 20)) < 68'(rhs_r)) ?
                    ST_ACCEPT : ST_REJECT;
          st_r <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_status <= stat_r;
          out_match_entry <= 6'(best_e_r);
          out_best_distance_sq <= best_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/gallery_nearest_neighbor_match_top.sv
// Gallery nearest-neighbor match, top level.
// Input channel in_*: one request per cycle while in_ready is high, for writes,
// commits, deletes and query elements. A query element with last set queues a
// search. While a search is queued or runs, in_ready is low; the loop is one
// gallery memory read and one multiply-accumulate a cycle.
// Output channel out_*: one result per search, held in a register until
// taken; a stalled receiver holds the result, and the next search runs but
// waits to output its result until the old one is taken. Reset clears the
// entry valid bits and resets thresholds to 16384 and 100; memories are not
// cleared.
// cfg_*: write enable, index (0 distance, 1 percent), data; only while idle.
module gallery_nearest_neighbor_match_top #(
  parameter int ENTRIES     = 64,
  parameter int VECTOR_LEN  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  gnnm_in_if.sink    in_ch,
  gnnm_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import gnnm_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

  logic [THR_W-1:0] thr_r;
  logic [PCT_W-1:0] pct_r;
  logic g_we, q_we, req_valid, req_take, busy;
  logic [EW-1:0] g_entry;
  logic [1:0] g_pose;
  logic [VW-1:0] g_idx, q_idx;
  logic [SAMPLE_BITS-1:0] wr_sample;
  logic [ENTRIES-1:0] valid_bits;
  search_req_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 20'd16384;
      pct_r <= 14'd100;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DIST) thr_r <= cfg_data;
      if (cfg_index == CFG_PCT)  pct_r <= cfg_data[PCT_W-1:0];
    end
  end

  gnnm_front #(.ENTRIES(ENTRIES), .VECTOR_LEN(VECTOR_LEN), .SAMPLE_BITS(SAMPLE_BITS),
               .EW(EW), .VW(VW)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .in_entry(in_ch.entry), .in_pose(in_ch.pose), .in_element_index(in_ch.element_index),
    .in_sample(in_ch.sample), .in_last(in_ch.last),
    .g_we, .g_entry, .g_pose, .g_idx, .q_we, .q_idx, .wr_sample, .valid_bits,
    .req_valid, .req, .req_take, .back_busy(busy)
  );

  gnnm_back #(.ENTRIES(ENTRIES), .VECTOR_LEN(VECTOR_LEN), .SAMPLE_BITS(SAMPLE_BITS),
              .EW(EW), .VW(VW)) u_back (
    .clk, .rst_n, .g_we, .g_entry, .g_pose, .g_idx, .q_we, .q_idx, .wr_sample,
    .valid_bits, .req_valid, .req, .req_take, .busy, .thr(thr_r), .pct(pct_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_match_entry(out_ch.match_entry),
    .out_best_distance_sq(out_ch.best_distance_sq)
  );
endmodule
